// File: src/cmffa_pkg.sv
// ----------------------------------------------------------------------------
// cmffa_pkg
// Shared widths and default sizes for the first-fit chunk map allocator.
// ----------------------------------------------------------------------------
package cmffa_pkg;

    // Default pool geometry.
    localparam int unsigned POOL_CHUNKS_DEF = 256;
    localparam int unsigned MAX_RUN_DEF     = 255;
    localparam int unsigned CHUNK_BYTES_DEF = 16;

    // Fixed widths of the item fields.
    localparam int unsigned REQ_W   = 16;
    localparam int unsigned START_W = 8;
    localparam int unsigned LFR_W   = 8;
    localparam int unsigned USED_W  = 9;

endpackage

// File: src/chunk_map_first_fit_allocator_unit.sv
// ----------------------------------------------------------------------------
// chunk_map_first_fit_allocator_unit
// First-fit run-length allocator over one chunk map held in a synchronous
// memory, with forward coalescing of the free run behind a new allocation
// and a rescan for the largest free run.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+-----------------------------
//  request   | in        | start, busy          | i_request_bytes
//  result    | out       | o_done (strobe)      | o_granted, o_start_chunk,
//            |           |                      | o_largest_free_run,
//            |           |                      | o_used_chunk_count
//
// A request is taken when start is high and busy is low. A rejected size
// (zero chunks, longer than MAX_RUN or longer than the pool) has its strobe
// in the cycle after accept; a request with no fit answers once the fit scan
// finds no room left for it. A granted item passes through the fit scan over
// the chunk map entries, the writing of its chunks, the tail check (skipped
// when the run ends at the pool's end), the coalescing of a free tail, the
// scan restart, the largest-run scan and the output register. Each visited
// entry is read through the single memory read port. After reset a clearing
// pass rebuilds every map entry, with busy held high. The result strobe lasts
// one cycle; the receiver cannot stall.
module chunk_map_first_fit_allocator_unit #(
    parameter int unsigned POOL_CHUNKS = cmffa_pkg::POOL_CHUNKS_DEF,
    parameter int unsigned MAX_RUN     = cmffa_pkg::MAX_RUN_DEF,
    parameter int unsigned CHUNK_BYTES = cmffa_pkg::CHUNK_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [cmffa_pkg::REQ_W-1:0]     i_request_bytes,
    output logic                            o_done,
    output logic                            o_granted,
    output logic [cmffa_pkg::START_W-1:0]   o_start_chunk,
    output logic [cmffa_pkg::LFR_W-1:0]     o_largest_free_run,
    output logic [cmffa_pkg::USED_W-1:0]    o_used_chunk_count
);

    localparam int unsigned IDX_W       = $clog2(POOL_CHUNKS);
    localparam int unsigned CNT_W       = $clog2(POOL_CHUNKS + 1);
    localparam int unsigned LEN_W       = $clog2(MAX_RUN + 1);
    localparam int unsigned SUM_W       = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 2;
    // Chunk size must be a power of two (the block does not check it); the byte to chunk conversion is a shift.
    localparam int unsigned CHUNK_SHIFT = $clog2(CHUNK_BYTES);
    localparam int unsigned LARGE_RST   = (MAX_RUN < POOL_CHUNKS) ? MAX_RUN : POOL_CHUNKS;

    localparam logic [SUM_W-1:0] POOL_S = SUM_W'(POOL_CHUNKS);
    localparam logic [SUM_W-1:0] MAX_S  = SUM_W'(MAX_RUN);
    localparam logic [IDX_W-1:0] LAST_I = IDX_W'(POOL_CHUNKS - 1);
    localparam logic [LEN_W-1:0] MAX_L  = LEN_W'(MAX_RUN);
    localparam logic [LEN_W-1:0] SEG_LAST = LEN_W'(MAX_RUN - 1);

    typedef struct packed {
        logic             head;
        logic             ocp;
        logic [LEN_W-1:0] len;
    } t_entry;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_FIT,
        S_MARK,
        S_TAIL,
        S_COAL,
        S_LSTART,
        S_LARGE
    } t_state;

    // Chunk map memory, one synchronous read port and one write port.
    t_entry             mem [POOL_CHUNKS];
    t_entry             r_rd;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    t_entry             mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_i, n_i;
    logic [IDX_W-1:0]   r_at, n_at;
    logic [LEN_W-1:0]   r_want, n_want;
    logic [LEN_W-1:0]   r_k, n_k;
    logic [LEN_W-1:0]   r_best, n_best;
    logic [LEN_W-1:0]   r_largest, n_largest;
    logic [CNT_W-1:0]   r_used, n_used;
    logic                           r_done, n_done;
    logic                           r_granted, n_granted;
    logic [cmffa_pkg::START_W-1:0]  r_start, n_start;
    logic [cmffa_pkg::LFR_W-1:0]    r_lfr, n_lfr;
    logic [cmffa_pkg::USED_W-1:0]   r_used_o, n_used_o;

    logic [cmffa_pkg::REQ_W-1:0] want_full;
    logic [LEN_W-1:0]            step;
    logic [SUM_W-1:0]            nxt;
    logic [SUM_W-1:0]            tail;
    logic [SUM_W-1:0]            rest;
    logic [SUM_W-1:0]            kk_sum;
    logic [LEN_W-1:0]            kk;
    logic [LEN_W-1:0]            nb;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= mem[mem_raddr];
    end

    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_at      = r_at;
        n_want    = r_want;
        n_k       = r_k;
        n_best    = r_best;
        n_largest = r_largest;
        n_used    = r_used;
        n_done    = 1'b0;
        n_granted = r_granted;
        n_start   = r_start;
        n_lfr     = r_lfr;
        n_used_o  = r_used_o;
        mem_we    = 1'b0;
        mem_waddr = r_i;
        mem_wdata = '0;
        mem_raddr = r_i;

        want_full = i_request_bytes >> CHUNK_SHIFT;
        step      = (r_rd.len == '0) ? LEN_W'(1) : r_rd.len;
        nxt       = SUM_W'(r_i) + (r_rd.head ? SUM_W'(step) : SUM_W'(1));
        tail      = SUM_W'(r_at) + SUM_W'(r_want);
        rest      = POOL_S - SUM_W'(r_i);
        kk        = r_k + LEN_W'(1);
        kk_sum    = tail + SUM_W'(kk);
        nb        = (r_rd.head && !r_rd.ocp && (r_rd.len > r_best)) ? r_rd.len : r_best;

        case (r_state)
            S_CLR: begin
                // Rebuild the reset map: a free head every MAX_RUN entries.
                mem_we    = 1'b1;
                mem_waddr = r_i;
                if (r_k == '0) begin
                    mem_wdata.head = 1'b1;
                    mem_wdata.len  = (rest < MAX_S) ? LEN_W'(rest) : MAX_L;
                end
                n_k = (r_k == SEG_LAST) ? '0 : r_k + LEN_W'(1);
                if (r_i == LAST_I) begin
                    n_state = S_IDLE;
                end else begin
                    n_i = r_i + IDX_W'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_want = LEN_W'(want_full);
                    if (want_full == '0 || want_full > cmffa_pkg::REQ_W'(MAX_RUN) ||
                        want_full > cmffa_pkg::REQ_W'(POOL_CHUNKS)) begin
                        n_done    = 1'b1;
                        n_granted = 1'b0;
                        n_start   = '0;
                        n_lfr     = cmffa_pkg::LFR_W'(r_largest);
                        n_used_o  = cmffa_pkg::USED_W'(r_used);
                    end else begin
                        n_i       = '0;
                        mem_raddr = '0;
                        n_state   = S_FIT;
                    end
                end
            end
            S_FIT: begin
                if (r_rd.head && !r_rd.ocp && (r_rd.len >= r_want)) begin
                    n_at    = r_i;
                    n_k     = '0;
                    n_state = S_MARK;
                end else if (nxt + SUM_W'(r_want) <= POOL_S) begin
                    n_i       = IDX_W'(nxt);
                    mem_raddr = IDX_W'(nxt);
                end else begin
                    n_done    = 1'b1;
                    n_granted = 1'b0;
                    n_start   = '0;
                    n_lfr     = cmffa_pkg::LFR_W'(r_largest);
                    n_used_o  = cmffa_pkg::USED_W'(r_used);
                    n_state   = S_IDLE;
                end
            end
            S_MARK: begin
                mem_we    = 1'b1;
                mem_waddr = r_at + IDX_W'(r_k);
                mem_wdata.ocp = 1'b1;
                if (r_k == '0) begin
                    mem_wdata.head = 1'b1;
                    mem_wdata.len  = r_want;
                end
                if (r_k == r_want - LEN_W'(1)) begin
                    n_used = r_used + CNT_W'(r_want);
                    if (tail < POOL_S) begin
                        // The tail lies outside the run being written.
                        mem_raddr = IDX_W'(tail);
                        n_state   = S_TAIL;
                    end else begin
                        n_state = S_LSTART;
                    end
                end else begin
                    n_k = r_k + LEN_W'(1);
                end
            end
            S_TAIL: begin
                if (r_rd.ocp) begin
                    n_state = S_LSTART;
                end else if ((tail + SUM_W'(1) < POOL_S) && (MAX_RUN > 1)) begin
                    n_k       = LEN_W'(1);
                    mem_raddr = IDX_W'(tail + SUM_W'(1));
                    n_state   = S_COAL;
                end else begin
                    mem_we         = 1'b1;
                    mem_waddr      = IDX_W'(tail);
                    mem_wdata.head = 1'b1;
                    mem_wdata.len  = LEN_W'(1);
                    n_state        = S_LSTART;
                end
            end
            S_COAL: begin
                if (!r_rd.ocp && (kk_sum < POOL_S) && (kk < MAX_L)) begin
                    n_k       = kk;
                    mem_raddr = IDX_W'(kk_sum);
                end else begin
                    mem_we         = 1'b1;
                    mem_waddr      = IDX_W'(tail);
                    mem_wdata.head = 1'b1;
                    mem_wdata.len  = r_rd.ocp ? r_k : kk;
                    n_state        = S_LSTART;
                end
            end
            S_LSTART: begin
                n_i       = '0;
                n_best    = '0;
                mem_raddr = '0;
                n_state   = S_LARGE;
            end
            S_LARGE: begin
                if ((nxt < POOL_S) && (nb < MAX_L)) begin
                    n_best    = nb;
                    n_i       = IDX_W'(nxt);
                    mem_raddr = IDX_W'(nxt);
                end else begin
                    n_largest = nb;
                    n_done    = 1'b1;
                    n_granted = 1'b1;
                    n_start   = cmffa_pkg::START_W'(r_at);
                    n_lfr     = cmffa_pkg::LFR_W'(nb);
                    n_used_o  = cmffa_pkg::USED_W'(r_used);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_i       <= '0;
            r_k       <= '0;
            r_best    <= '0;
            r_largest <= LEN_W'(LARGE_RST);
            r_used    <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_i       <= n_i;
            r_k       <= n_k;
            r_best    <= n_best;
            r_largest <= n_largest;
            r_used    <= n_used;
            r_done    <= n_done;
        end
        r_at      <= n_at;
        r_want    <= n_want;
        r_granted <= n_granted;
        r_start   <= n_start;
        r_lfr     <= n_lfr;
        r_used_o  <= n_used_o;
    end

    assign busy               = (r_state != S_IDLE);
    assign o_done             = r_done;
    assign o_granted          = r_granted;
    assign o_start_chunk      = r_start;
    assign o_largest_free_run = r_lfr;
    assign o_used_chunk_count = r_used_o;

    // The result strobe comes only while the sequencer is idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // The map is never written while idle.
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("chunk map written while idle");

    // Occupied chunk count stays within the pool.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(POOL_CHUNKS))
        else $error("used chunk count exceeds pool");

    // A failed item leaves the occupied count untouched.
    a_fail_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_granted) |-> (o_used_chunk_count == cmffa_pkg::USED_W'(r_used)))
        else $error("failed item changed the used count");

    // The largest free run never exceeds the maximum run length.
    a_largest_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_largest <= MAX_L)
        else $error("largest free run out of range");

endmodule

// File: verif/chunk_map_alloc_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_map_alloc_monitor
// Watches the request and result channels of the first-fit chunk allocator.
// It keeps a shadow chunk map and uses it to work out the answer to each
// accepted request. Each result strobe is then checked against the oldest
// outstanding answer, one field at a time.
// ----------------------------------------------------------------------------
module chunk_map_alloc_monitor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [cmffa_pkg::REQ_W-1:0]   i_request_bytes,
    input  logic                          i_done,
    input  logic                          i_granted,
    input  logic [cmffa_pkg::START_W-1:0] i_start_chunk,
    input  logic [cmffa_pkg::LFR_W-1:0]   i_largest_free_run,
    input  logic [cmffa_pkg::USED_W-1:0]  i_used_chunk_count,
    output int                            o_mismatches,
    output int                            o_outstanding,
    output int                            o_granted_cnt,
    output int                            o_zero_cnt,
    output int                            o_oversize_cnt,
    output int                            o_nofit_cnt
);

    localparam int unsigned POOL_CHUNKS = cmffa_pkg::POOL_CHUNKS_DEF;
    localparam int unsigned MAX_RUN     = cmffa_pkg::MAX_RUN_DEF;
    localparam int unsigned CHUNK_BYTES = cmffa_pkg::CHUNK_BYTES_DEF;

    typedef struct {
        logic       head;
        logic       taken;
        logic [7:0] len;
    } map_slot_t;

    typedef struct {
        logic                          granted;
        logic [cmffa_pkg::START_W-1:0] start_chunk;
        logic [cmffa_pkg::LFR_W-1:0]   largest;
        logic [cmffa_pkg::USED_W-1:0]  used;
    } alloc_answer_t;

    map_slot_t     shadow_map [POOL_CHUNKS];
    int unsigned   largest_free;
    int unsigned   used_chunks;
    alloc_answer_t awaited_answers [$];

    int mismatch_count = 0;
    int granted_count  = 0;
    int zero_count     = 0;
    int oversize_count = 0;
    int nofit_count    = 0;

    // Runs one request against the shadow map and returns what the block
    // should answer. A failed request leaves the map and counters alone.
    function automatic alloc_answer_t allocate_in_shadow_map(
        logic [cmffa_pkg::REQ_W-1:0] bytes
    );
        alloc_answer_t ans;
        int unsigned   want;
        int unsigned   pos;
        int unsigned   k;
        int unsigned   tail;
        int            fit_at;
        want   = bytes / CHUNK_BYTES;
        fit_at = -1;
        ans    = '{default: '0};
        if (want != 0 && want <= MAX_RUN) begin
            pos = 0;
            while (fit_at < 0 && pos + want <= POOL_CHUNKS) begin
                if (shadow_map[pos].head) begin
                    if (!shadow_map[pos].taken && shadow_map[pos].len >= want) begin
                        fit_at = pos;
                    end else begin
                        // A zero-length head is stepped over like a length of one.
                        pos += (shadow_map[pos].len == 0) ? 1 : shadow_map[pos].len;
                    end
                end else begin
                    pos++;
                end
            end
        end
        if (fit_at >= 0) begin
            shadow_map[fit_at] = '{head: 1'b1, taken: 1'b1, len: 8'(want)};
            for (k = 1; k < want && fit_at + k < POOL_CHUNKS; k++) begin
                shadow_map[fit_at + k] = '{head: 1'b0, taken: 1'b1, len: 8'd0};
            end
            // Rebuild the free head behind the new run, merging forward up to
            // the longest run allowed.
            tail = fit_at + want;
            if (tail < POOL_CHUNKS && !shadow_map[tail].taken) begin
                k = 1;
                while (tail + k < POOL_CHUNKS && k < MAX_RUN && !shadow_map[tail + k].taken) begin
                    k++;
                end
                shadow_map[tail] = '{head: 1'b1, taken: 1'b0, len: 8'(k)};
            end
            used_chunks += want;
            largest_free = 0;
            pos = 0;
            while (pos < POOL_CHUNKS && largest_free < MAX_RUN) begin
                if (shadow_map[pos].head) begin
                    if (!shadow_map[pos].taken && shadow_map[pos].len > largest_free) begin
                        largest_free = shadow_map[pos].len;
                    end
                    pos += (shadow_map[pos].len == 0) ? 1 : shadow_map[pos].len;
                end else begin
                    pos++;
                end
            end
            ans.granted     = 1'b1;
            ans.start_chunk = fit_at[cmffa_pkg::START_W-1:0];
        end
        ans.largest = largest_free[cmffa_pkg::LFR_W-1:0];
        ans.used    = used_chunks[cmffa_pkg::USED_W-1:0];
        return ans;
    endfunction

    task automatic compare_field(string field, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, field, want_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        alloc_answer_t ans;
        int unsigned   want;
        if (!i_rst_n) begin
            for (int unsigned i = 0; i < POOL_CHUNKS; i++) begin
                shadow_map[i] = '{head: 1'b0, taken: 1'b0, len: 8'd0};
            end
            for (int unsigned p = 0; p < POOL_CHUNKS; p += MAX_RUN) begin
                shadow_map[p] = '{head: 1'b1, taken: 1'b0,
                                  len: 8'((POOL_CHUNKS - p < MAX_RUN) ? POOL_CHUNKS - p
                                                                       : MAX_RUN)};
            end
            largest_free = (MAX_RUN < POOL_CHUNKS) ? MAX_RUN : POOL_CHUNKS;
            used_chunks  = 0;
            awaited_answers.delete();
        end else begin
            // Results are checked before this edge's request is queued.
            if (i_done) begin
                if (awaited_answers.size() == 0) begin
                    $display("%0t ns: result strobe with no request outstanding", $time);
                    mismatch_count++;
                end else begin
                    ans = awaited_answers.pop_front();
                    compare_field("granted", ans.granted, i_granted);
                    compare_field("start_chunk", ans.start_chunk, i_start_chunk);
                    compare_field("largest_free_run", ans.largest, i_largest_free_run);
                    compare_field("used_chunk_count", ans.used, i_used_chunk_count);
                end
            end
            if (i_start && !i_busy) begin
                want = i_request_bytes / CHUNK_BYTES;
                ans  = allocate_in_shadow_map(i_request_bytes);
                awaited_answers.push_back(ans);
                if (want == 0) begin
                    zero_count++;
                end else if (want > MAX_RUN) begin
                    oversize_count++;
                end else if (ans.granted) begin
                    granted_count++;
                end else begin
                    nofit_count++;
                end
            end
        end
        o_mismatches   <= mismatch_count;
        o_outstanding  <= awaited_answers.size();
        o_granted_cnt  <= granted_count;
        o_zero_cnt     <= zero_count;
        o_oversize_cnt <= oversize_count;
        o_nofit_cnt    <= nofit_count;
    end

endmodule

// File: verif/chunk_map_first_fit_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_map_first_fit_allocator_unit_tb
// Drives allocation requests into the first-fit chunk allocator: a directed
// opening with size extremes and failure cases, then random requests under
// three sender idling patterns. A monitor beside the block checks each result.
// ----------------------------------------------------------------------------
module chunk_map_first_fit_allocator_unit_tb;

    localparam int RANDOM_PER_PHASE = 382;
    localparam int DRAIN_CYCLES     = 1100;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic [cmffa_pkg::REQ_W-1:0]   i_request_bytes;
    logic                          o_done;
    logic                          o_granted;
    logic [cmffa_pkg::START_W-1:0] o_start_chunk;
    logic [cmffa_pkg::LFR_W-1:0]   o_largest_free_run;
    logic [cmffa_pkg::USED_W-1:0]  o_used_chunk_count;

    int mismatches;
    int outstanding;
    int granted_cnt;
    int zero_cnt;
    int oversize_cnt;
    int nofit_cnt;
    int gap_pct;

    chunk_map_first_fit_allocator_unit i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_request_bytes    (i_request_bytes),
        .o_done             (o_done),
        .o_granted          (o_granted),
        .o_start_chunk      (o_start_chunk),
        .o_largest_free_run (o_largest_free_run),
        .o_used_chunk_count (o_used_chunk_count)
    );

    chunk_map_alloc_monitor i_monitor (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_busy             (busy),
        .i_request_bytes    (i_request_bytes),
        .i_done             (o_done),
        .i_granted          (o_granted),
        .i_start_chunk      (o_start_chunk),
        .i_largest_free_run (o_largest_free_run),
        .i_used_chunk_count (o_used_chunk_count),
        .o_mismatches       (mismatches),
        .o_outstanding      (outstanding),
        .o_granted_cnt      (granted_cnt),
        .o_zero_cnt         (zero_cnt),
        .o_oversize_cnt     (oversize_cnt),
        .o_nofit_cnt        (nofit_cnt)
    );

    initial i_clk = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Presents one request and returns at the edge that accepts it. The start
    // line stays high so the next item can follow without a gap.
    task automatic issue_request(input logic [cmffa_pkg::REQ_W-1:0] bytes);
        while ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_request_bytes <= bytes;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results;
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Most random sizes are refused outright so that the 256-chunk pool,
    // which is never freed, keeps granting well into the last phase.
    function automatic logic [cmffa_pkg::REQ_W-1:0] pick_request_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            return cmffa_pkg::REQ_W'($urandom_range(0, 15));
        end else if (r < 66) begin
            return cmffa_pkg::REQ_W'($urandom_range(4096, 65535));
        end else if (r < 79) begin
            return cmffa_pkg::REQ_W'($urandom_range(16, 47));
        end else if (r < 80) begin
            return cmffa_pkg::REQ_W'($urandom_range(48, 255));
        end else if (r < 83) begin
            return cmffa_pkg::REQ_W'($urandom());
        end else begin
            // Close to the longest run: these mostly run the fit scan to the end.
            return cmffa_pkg::REQ_W'($urandom_range(3968, 4095));
        end
    endfunction

    initial begin
        logic [cmffa_pkg::REQ_W-1:0] directed_sizes [$];
        int                          phase_gap [3];
        start           <= 1'b0;
        i_request_bytes <= '0;
        i_rst_n         <= 1'b0;
        gap_pct          = 14;
        phase_gap        = '{14, 65, 0};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero chunks, one chunk at the low and high byte edge, a run longer
        // than any free run, oversize requests, and alternating bit patterns.
        directed_sizes = '{16'd0, 16'd15, 16'd16, 16'd31, 16'd32, 16'd47, 16'd4095,
                           16'd4096, 16'hFFFF, 16'h5555, 16'hAAAA, 16'd255, 16'd240,
                           16'd17, 16'hFFF0, 16'd4080, 16'd1};
        foreach (directed_sizes[i]) begin
            issue_request(directed_sizes[i]);
        end
        wait_for_results();

        for (int ph = 0; ph < 3; ph++) begin
            gap_pct = phase_gap[ph];
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                issue_request(pick_request_size());
            end
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Requests checked: %0d granted, %0d zero-size, %0d oversize, %0d without a fit.",
                 granted_cnt, zero_cnt, oversize_cnt, nofit_cnt);
        $display("Sender gaps ran at 14, 65 and 0 percent; pool usage ended at %0d chunks.",
                 o_used_chunk_count);
        if (mismatches == 0 && outstanding == 0) begin
            $display("chunk_map_first_fit_allocator_unit: match");
        end else begin
            $display("chunk_map_first_fit_allocator_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Timed out waiting for the allocator.");
        $display("chunk_map_first_fit_allocator_unit: mismatch");
        $finish;
    end

endmodule
